### design/dss_pkg.sv
package dss_pkg;

  // operation codes
  localparam logic [2:0] OP_PUSH_A = 3'd0;
  localparam logic [2:0] OP_PUSH_B = 3'd1;
  localparam logic [2:0] OP_POP_A  = 3'd2;
  localparam logic [2:0] OP_POP_B  = 3'd3;
  localparam logic [2:0] OP_PEEK_A = 3'd4;
  localparam logic [2:0] OP_PEEK_B = 3'd5;

  // result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // input transaction payload
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } in_item_t;

  // output transaction payload
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] top_word;
    logic [4:0]         depth_a;
    logic [4:0]         depth_b;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch_item;
    logic execute;
    logic load_result;
  } dss_cmd_t;

endpackage

### design/dss_ctrl.sv
module dss_ctrl
  import dss_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output dss_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       slot_free;

  // output register can take a new result this cycle
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // command decode and next state
  always_comb begin
    state_next      = state;
    cmd.latch_item  = 1'b0;
    cmd.execute     = 1'b0;
    cmd.load_result = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_next     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_next  = S_FIN;
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.load_result = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_result) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/dss_datapath.sv
module dss_datapath
  import dss_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic      clk,
  input  logic      rst,
  input  dss_cmd_t  cmd,
  input  in_item_t  in_data,
  output out_item_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [CW:0] DEPTH_W = (CW + 1)'(DEPTH);

  in_item_t    item;
  logic [CW-1:0] count_a;
  logic [CW-1:0] count_b;
  logic [CW-1:0] count_a_next;
  logic [CW-1:0] count_b_next;
  logic [CW:0]   count_sum;
  logic          full;
  logic [CW:0]   addr_wide;
  logic [AW-1:0] addr;
  logic          mem_we;
  logic          mem_re;
  logic [1:0]    res_status;
  logic [1:0]    res_status_next;
  logic          peek_hit;
  logic [31:0]   rd_data;
  logic [31:0]   depth_a_wide;
  logic [31:0]   depth_b_wide;
  logic [31:0]   mem [DEPTH];

  assign count_sum = {1'b0, count_a} + {1'b0, count_b};
  assign full      = (count_sum >= DEPTH_W);
  assign addr      = addr_wide[AW-1:0];

  // operation decode: address, memory strobe, counts and status
  always_comb begin
    count_a_next    = count_a;
    count_b_next    = count_b;
    res_status_next = ST_DONE;
    addr_wide       = '0;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    unique case (item.operation)
      OP_PUSH_A: begin
        addr_wide = {1'b0, count_a};
        if (full) begin
          res_status_next = ST_FULL;
        end else begin
          mem_we       = 1'b1;
          count_a_next = count_a + CW'(1);
        end
      end
      OP_PUSH_B: begin
        addr_wide = DEPTH_W - (CW + 1)'(1) - {1'b0, count_b};
        if (full) begin
          res_status_next = ST_FULL;
        end else begin
          mem_we       = 1'b1;
          count_b_next = count_b + CW'(1);
        end
      end
      OP_POP_A: begin
        if (count_a == '0) begin
          res_status_next = ST_EMPTY;
        end else begin
          count_a_next = count_a - CW'(1);
        end
      end
      OP_POP_B: begin
        if (count_b == '0) begin
          res_status_next = ST_EMPTY;
        end else begin
          count_b_next = count_b - CW'(1);
        end
      end
      OP_PEEK_A: begin
        addr_wide = {1'b0, count_a} - (CW + 1)'(1);
        if (count_a == '0) begin
          res_status_next = ST_EMPTY;
        end else begin
          mem_re = 1'b1;
        end
      end
      OP_PEEK_B: begin
        addr_wide = DEPTH_W - {1'b0, count_b};
        if (count_b == '0) begin
          res_status_next = ST_EMPTY;
        end else begin
          mem_re = 1'b1;
        end
      end
      default: begin
        res_status_next = ST_DONE;
      end
    endcase
  end

  // stack counts
  always_ff @(posedge clk) begin
    if (rst) begin
      count_a <= '0;
      count_b <= '0;
    end else if (cmd.execute) begin
      count_a <= count_a_next;
      count_b <= count_b_next;
    end
  end

  // item capture and execute-stage result bits
  always_ff @(posedge clk) begin
    if (cmd.latch_item) begin
      item <= in_data;
    end
    if (cmd.execute) begin
      res_status <= res_status_next;
      peek_hit   <= mem_re;
    end
  end

  // shared word memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.execute && mem_we) begin
      mem[addr] <= item.value;
    end
    if (cmd.execute && mem_re) begin
      rd_data <= mem[addr];
    end
  end

  assign depth_a_wide = 32'(count_a);
  assign depth_b_wide = 32'(count_b);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      out_data.status   <= res_status;
      out_data.top_word <= peek_hit ? rd_data : '0;
      out_data.depth_a  <= depth_a_wide[4:0];
      out_data.depth_b  <= depth_b_wide[4:0];
    end
  end

endmodule

### design/dual_stack_shared_memory.sv
// Two stacks sharing one word memory: stack A grows up from word 0,
// stack B grows down from word DEPTH-1.
// Input channel (in_valid/in_ready/in_data) carries one operation per
// transaction: push, pop or peek on either stack, plus the word to push.
// Output channel (out_valid/out_ready/out_data) returns exactly one result
// per input transaction: status, top word for a peek, and both depths.
// After acceptance, the controller steps through its execute and finish
// states; out_valid rises when finish loads the result into a free output register.
// Each operation walks the capture, execute (memory access) and result-load
// steps of the controller before the next operation can be accepted.
// Items are processed one at a time; in_ready is high only while the
// controller is idle.
// The output register holds a finished result while the receiver stalls;
// the next operation is accepted and executed meanwhile, and only its final
// load step waits until the held result is taken.
// Reset clears both stack counts and the controller; memory contents are
// not cleared, since words are only read after they were pushed.
module dual_stack_shared_memory
  import dss_pkg::*;
#(
  parameter int DEPTH = 16
)
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dss_cmd_t cmd;

  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // one operation in flight: an accepted transaction closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an operation is in flight");

  // a refused result never carries a word
  a_empty_no_word: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != ST_DONE) |-> out_data.top_word == '0)
    else $error("refused operation returned a nonzero word");

  // status is always a defined code
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.status == ST_DONE) || (out_data.status == ST_FULL)
                  || (out_data.status == ST_EMPTY))
    else $error("undefined status code");

  // a result cannot appear in the cycle right after acceptance
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule
